[rtl/md5md_pkg.sv]
// md5md_pkg: constants, tables and helper functions of the md5 message digest
// used by md5md_round and md5_message_digest; no dependencies

package md5md_pkg;

  localparam int WordW     = 32;
  localparam int BlockWords = 16;
  localparam int AddrW     = 4;
  localparam int Rounds    = 64;
  localparam int RoundW    = 6;

  localparam logic [31:0] InitA  = 32'h67452301;
  localparam logic [31:0] InitB  = 32'hefcdab89;
  localparam logic [31:0] InitC  = 32'h98badcfe;
  localparam logic [31:0] InitD  = 32'h10325476;
  localparam logic [31:0] PadOne = 32'h00000080;

  typedef logic [31:0] word_t;

  // additive step constants, one per round
  localparam word_t StepConst [Rounds] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // message word index used by a round
  function automatic logic [AddrW-1:0] msg_index(input logic [RoundW-1:0] r);
    logic [AddrW-1:0] lo;
    lo = r[AddrW-1:0];
    case (r[RoundW-1:RoundW-2])
      2'd0:    msg_index = lo;
      2'd1:    msg_index = AddrW'(lo * 4'd5 + 4'd1);
      2'd2:    msg_index = AddrW'(lo * 4'd3 + 4'd5);
      default: msg_index = AddrW'(lo * 4'd7);
    endcase
  endfunction

  // left rotate amount of a round
  function automatic logic [4:0] rot_amount(input logic [RoundW-1:0] r);
    logic [3:0] sel;
    sel = {r[RoundW-1:RoundW-2], r[1:0]};
    case (sel)
      4'h0: rot_amount = 5'd7;   4'h1: rot_amount = 5'd12;
      4'h2: rot_amount = 5'd17;  4'h3: rot_amount = 5'd22;
      4'h4: rot_amount = 5'd5;   4'h5: rot_amount = 5'd9;
      4'h6: rot_amount = 5'd14;  4'h7: rot_amount = 5'd20;
      4'h8: rot_amount = 5'd4;   4'h9: rot_amount = 5'd11;
      4'ha: rot_amount = 5'd16;  4'hb: rot_amount = 5'd23;
      4'hc: rot_amount = 5'd6;   4'hd: rot_amount = 5'd10;
      4'he: rot_amount = 5'd15;  default: rot_amount = 5'd21;
    endcase
  endfunction

  // final partial word: keep valid low bytes, put the pad byte above them (a full word passes unchanged)
  function automatic word_t pad_word(input word_t w, input logic [2:0] n);
    case (n)
      3'd0:    pad_word = PadOne;
      3'd1:    pad_word = {16'h0000, 8'h80, w[7:0]};
      3'd2:    pad_word = {8'h00, 8'h80, w[15:0]};
      3'd3:    pad_word = {8'h80, w[23:0]};
      default: pad_word = w;
    endcase
  endfunction

endpackage

[rtl/md5_message_digest.sv]
// md5 message digest: word in, four digest beats out per message
// a last beat is followed by padding writes, then one or two blocks, each a prime,
// 64 rounds and a fold, before the first digest beat
// input stalls while a block is padded or compressed, at one round per cycle
// reset: synchronous, chaining value to md5 initial values, length and fill to zero
// depends on md5md_pkg, md5md_ram, md5md_round

module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StPrime = 3'd2;
  localparam logic [2:0] StComp  = 3'd3;
  localparam logic [2:0] StFold  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]  state;
  logic [2:0]  ret_state;
  logic [md5md_pkg::AddrW-1:0]  fill;
  logic [md5md_pkg::RoundW-1:0] round;
  logic [63:0] bit_length;
  logic        pad_pend;
  logic        len_lo;
  logic [1:0]  out_idx;
  md5md_pkg::word_t cv [4];
  md5md_pkg::word_t a, b, c, d;

  logic        wr_en;
  md5md_pkg::word_t wr_data;
  logic [md5md_pkg::AddrW-1:0] rd_addr;
  md5md_pkg::word_t rd_data;
  md5md_pkg::word_t b_new;
  logic [2:0]  n_sat;
  logic        in_beat;
  logic        out_beat;

  assign in_stall  = (state != StIdle);
  assign in_beat   = in_valid && !in_stall;
  assign out_valid = (state == StOut);
  assign out_beat  = out_valid && !out_stall;
  assign n_sat     = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

  // digest beat payload straight from the chaining registers
  assign digest_word = cv[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 2'd3);

  // write data for the message block
  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (in_beat) begin
      wr_en   = 1'b1;
      wr_data = last_item ? md5md_pkg::pad_word(data_word, n_sat) : data_word;
    end else if (state == StPad) begin
      wr_en = 1'b1;
      if (pad_pend) begin
        wr_data = md5md_pkg::PadOne;
      end else if (fill == 4'd14) begin
        wr_data = bit_length[31:0];
      end else if (fill == 4'd15 && len_lo) begin
        wr_data = bit_length[63:32];
      end else begin
        wr_data = '0;
      end
    end
  end

  // prefetch the message word of the next round
  assign rd_addr = (state == StPrime) ? md5md_pkg::msg_index('0)
                                      : md5md_pkg::msg_index(round + 6'd1);

  md5md_ram #(
    .WIDTH(md5md_pkg::WordW),
    .DEPTH(md5md_pkg::BlockWords)
  ) u_block (
    .clk  (clk),
    .we   (wr_en),
    .waddr(fill),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  md5md_round u_round (
    .a    (a),
    .b    (b),
    .c    (c),
    .d    (d),
    .m    (rd_data),
    .round(round),
    .b_new(b_new)
  );

  // working variables, no reset needed
  always_ff @(posedge clk) begin
    if (state == StPrime) begin
      a <= cv[0];
      b <= cv[1];
      c <= cv[2];
      d <= cv[3];
    end else if (state == StComp) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_new;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= StIdle;
      ret_state  <= StIdle;
      fill       <= '0;
      round      <= '0;
      bit_length <= '0;
      pad_pend   <= 1'b0;
      len_lo     <= 1'b0;
      out_idx    <= '0;
      cv[0]      <= md5md_pkg::InitA;
      cv[1]      <= md5md_pkg::InitB;
      cv[2]      <= md5md_pkg::InitC;
      cv[3]      <= md5md_pkg::InitD;
    end else begin
      case (state)
        StIdle: begin
          if (in_beat) begin
            fill <= fill + 4'd1;
            if (!last_item) begin
              bit_length <= bit_length + 64'd32;
              if (fill == 4'd15) begin
                state     <= StPrime;
                ret_state <= StIdle;
              end
            end else begin
              bit_length <= bit_length + {58'd0, n_sat, 3'b000};
              pad_pend   <= (n_sat == 3'd4);
              len_lo     <= 1'b0;
              if (fill == 4'd15) begin
                state     <= StPrime;
                ret_state <= StPad;
              end else begin
                state <= StPad;
              end
            end
          end
        end
        StPad: begin
          fill <= fill + 4'd1;
          if (pad_pend) begin
            pad_pend <= 1'b0;
            if (fill == 4'd15) begin
              state     <= StPrime;
              ret_state <= StPad;
            end
          end else if (fill == 4'd14) begin
            len_lo <= 1'b1;
          end else if (fill == 4'd15) begin
            state     <= StPrime;
            ret_state <= len_lo ? StOut : StPad;
          end
        end
        StPrime: begin
          round <= '0;
          state <= StComp;
        end
        StComp: begin
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= StFold;
          end
        end
        StFold: begin
          cv[0] <= cv[0] + a;
          cv[1] <= cv[1] + b;
          cv[2] <= cv[2] + c;
          cv[3] <= cv[3] + d;
          state <= ret_state;
        end
        StOut: begin
          if (out_beat) begin
            out_idx <= out_idx + 2'd1;
            if (out_idx == 2'd3) begin
              cv[0]      <= md5md_pkg::InitA;
              cv[1]      <= md5md_pkg::InitB;
              cv[2]      <= md5md_pkg::InitC;
              cv[3]      <= md5md_pkg::InitD;
              bit_length <= '0;
              fill       <= '0;
              state      <= StIdle;
            end
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule

[rtl/md5md_ram.sv]
// md5md_ram: generic single write port, single read port ram
// registered read data; no dependencies

module md5md_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/md5md_round.sv]
// md5md_round: one md5 compression step, combinational
// depends on md5md_pkg for the step constants and rotate table

module md5md_round (
  input  md5md_pkg::word_t              a,
  input  md5md_pkg::word_t              b,
  input  md5md_pkg::word_t              c,
  input  md5md_pkg::word_t              d,
  input  md5md_pkg::word_t              m,
  input  logic [md5md_pkg::RoundW-1:0]  round,
  output md5md_pkg::word_t              b_new
);

  md5md_pkg::word_t f;
  md5md_pkg::word_t sum;
  logic [63:0]      rot;
  logic [4:0]       s;

  // round function by group of sixteen
  always_comb begin
    case (round[md5md_pkg::RoundW-1:md5md_pkg::RoundW-2])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  // add, rotate, add
  assign sum   = a + f + md5md_pkg::StepConst[round] + m;
  assign s     = md5md_pkg::rot_amount(round);
  assign rot   = {sum, sum} << s;
  assign b_new = b + rot[63:32];

endmodule
